[hw/rtl/prpi_pkg.sv]
// Shared types and constants for the PageRank power-iteration engine.
`default_nettype none
package prpi_pkg;
  localparam int RANK_W    = 32;
  localparam int RANK_FRAC = 30;
  localparam int FIELD_W   = 10;
  localparam logic [RANK_W-1:0] RANK_ONE = RANK_W'(1) << RANK_FRAC;

  localparam logic [1:0] ACT_ADD_EDGE = 2'd0;
  localparam logic [1:0] ACT_RUN      = 2'd1;
  localparam logic [1:0] ACT_READ     = 2'd2;
  localparam logic [1:0] ACT_CLEAR    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic [1:0] REG_DAMPING  = 2'd0;
  localparam logic [1:0] REG_LIMIT    = 2'd1;
  localparam logic [1:0] REG_TOL      = 2'd2;

  typedef struct packed {
    logic              start;
    logic [RANK_W-1:0] dividend;
    logic [RANK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [RANK_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/prpi_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module prpi_div import prpi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  localparam int CNT_W = $clog2(RANK_W + 1);

  logic [RANK_W-1:0] quo;
  logic [RANK_W-1:0] dsr;
  logic [RANK_W:0]   rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [RANK_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem[RANK_W-1:0], quo[RANK_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= CNT_W'(RANK_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
        quo <= {quo[RANK_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.busy     = busy;
  assign rsp.quotient = quo;
endmodule
`default_nettype wire

[hw/rtl/pagerank_power_iteration.sv]
// PageRank power-iteration engine: edge store, rank memories and run sequencer.
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tuser action; tdata source, target, node index
//  m_*     | out | m_tvalid/m_tready | tuser status; tdata rank, iters, conv, nodes, edges
//  apb     | in  | psel/penable      | damping @0, iteration_limit @4, tolerance @8
// Add edge passes through S_ADD and read rank through S_READ before S_RESP; clear sweeps the out-degree memory.
// Run: two divides, old-rank fill; per iteration new-rank fill, edge pass (divider), diff sum.
// After reset the out-degree memory is swept over all MAX_NODES entries; no item is taken then.
// One item at a time; a finished result waits in the output register for m_tready.
`default_nettype none
module pagerank_power_iteration import prpi_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // source_node, target_node, node_index
  input  wire logic [1:0]  s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // rank_value, iterations_run, converged, node_count, edge_count
  output logic [1:0]       m_tuser,   // status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int NC_W   = $clog2(MAX_NODES + 1);
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DIFF_W = RANK_W + NC_W;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ADD, S_READ, S_RESP,
    S_DIV1, S_W1, S_DIV2, S_W2, S_FILL_OLD,
    S_ITER, S_FILL_NEW, S_EDGE_RD, S_EDGE_SRC, S_EDGE_DEG, S_EDGE_DIV, S_EDGE_ACC,
    S_DIFF_RD, S_DIFF_ACC, S_ITER_END
  } state_t;

  state_t state;

  logic [15:0]       damping;
  logic [7:0]        iteration_limit;
  logic [31:0]       tolerance;

  logic [ECNT_W-1:0] stored_edges;
  logic [NODE_W-1:0] highest_node;
  logic [7:0]        last_iterations;
  logic              last_converged;

  logic [NC_W-1:0]   i;
  logic [ECNT_W-1:0] e;
  logic [7:0]        it;
  logic              conv;
  logic              clr_resp;
  logic [NODE_W-1:0] src_r;
  logic [NODE_W-1:0] v_r;
  logic [RANK_W-1:0] init_r;
  logic [RANK_W-1:0] base_r;
  logic [RANK_W-1:0] term_r;
  logic [DIFF_W-1:0] diff;
  logic [1:0]        status_r;
  logic [RANK_W-1:0] rank_r;

  logic [NODE_W-1:0] esrc_mem [MAX_EDGES];
  logic [NODE_W-1:0] edst_mem [MAX_EDGES];
  logic [ECNT_W-1:0] deg_mem  [MAX_NODES];
  logic [RANK_W-1:0] old_mem  [MAX_NODES];
  logic [RANK_W-1:0] new_mem  [MAX_NODES];
  logic [NODE_W-1:0] esrc_q, edst_q;
  logic [ECNT_W-1:0] deg_q;
  logic [RANK_W-1:0] old_q, new_q;

  logic              edge_we;
  logic              deg_we, old_we, new_we;
  logic [NODE_W-1:0] deg_raddr, deg_waddr, old_raddr, new_raddr, new_waddr;
  logic [ECNT_W-1:0] deg_wdata;
  logic [RANK_W-1:0] old_wdata, new_wdata;

  div_req_t          dreq;
  div_rsp_t          drsp;

  logic              accept;
  logic [1:0]        in_act;
  logic [FIELD_W-1:0] in_src, in_dst, in_idx;
  logic [NC_W-1:0]   nc;
  logic              src_bad, full;
  logic [NC_W-1:0]   i_inc;
  logic [RANK_W:0]   acc_sum;
  logic [RANK_W-1:0] absdiff;
  logic [47:0]       prod;
  logic [16:0]       one_minus_d;
  logic              apb_wr;

  assign in_act   = s_tuser;
  assign in_src   = s_tdata[9:0];
  assign in_dst   = s_tdata[19:10];
  assign in_idx   = s_tdata[29:20];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign nc       = (stored_edges == '0) ? NC_W'(1) : NC_W'(highest_node) + NC_W'(1);
  assign src_bad  = (32'(in_src) >= 32'(MAX_NODES)) || (32'(in_dst) >= 32'(MAX_NODES));
  assign full     = 32'(stored_edges) >= 32'(MAX_EDGES);
  assign i_inc    = i + NC_W'(1);
  assign acc_sum  = {1'b0, new_q} + {1'b0, term_r};
  assign absdiff  = (new_q > old_q) ? new_q - old_q : old_q - new_q;
  assign prod     = 48'(drsp.quotient) * 48'(damping);
  assign one_minus_d = 17'h10000 - {1'b0, damping};

  prpi_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = RANK_ONE;
    dreq.divisor  = RANK_W'(nc);
    case (state)
      S_DIV1:     dreq.start = 1'b1;
      S_DIV2: begin
        dreq.start    = 1'b1;
        dreq.dividend = RANK_W'(one_minus_d) << (RANK_FRAC - 16);
      end
      S_EDGE_DEG: begin
        dreq.start    = (deg_q != '0);
        dreq.dividend = old_q;
        dreq.divisor  = RANK_W'(deg_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    edge_we   = accept && (in_act == ACT_ADD_EDGE) && !src_bad && !full;
    deg_we    = 1'b0;
    deg_waddr = i[NODE_W-1:0];
    deg_wdata = '0;
    deg_raddr = NODE_W'(in_src);
    old_we    = 1'b0;
    old_wdata = init_r;
    old_raddr = i[NODE_W-1:0];
    new_we    = 1'b0;
    new_waddr = i[NODE_W-1:0];
    new_wdata = base_r;
    new_raddr = i[NODE_W-1:0];
    case (state)
      S_IDLE:     old_raddr = NODE_W'(in_idx);
      S_CLR:      deg_we = 1'b1;
      S_ADD: begin
        deg_we    = 1'b1;
        deg_waddr = src_r;
        deg_wdata = deg_q + ECNT_W'(1);
      end
      S_FILL_OLD: old_we = 1'b1;
      S_FILL_NEW: new_we = 1'b1;
      S_EDGE_SRC: begin
        deg_raddr = esrc_q;
        old_raddr = esrc_q;
      end
      S_EDGE_DIV: new_raddr = v_r;
      S_EDGE_ACC: begin
        new_we    = 1'b1;
        new_waddr = v_r;
        new_wdata = acc_sum[RANK_W] ? '1 : acc_sum[RANK_W-1:0];
      end
      S_DIFF_ACC: begin
        old_we    = 1'b1;
        old_wdata = new_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      esrc_mem[stored_edges[EA_W-1:0]] <= NODE_W'(in_src);
      edst_mem[stored_edges[EA_W-1:0]] <= NODE_W'(in_dst);
    end
    esrc_q <= esrc_mem[e[EA_W-1:0]];
    edst_q <= edst_mem[e[EA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_q <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (old_we) old_mem[i[NODE_W-1:0]] <= old_wdata;
    old_q <= old_mem[old_raddr];
  end

  always_ff @(posedge clk) begin
    if (new_we) new_mem[new_waddr] <= new_wdata;
    new_q <= new_mem[new_raddr];
  end

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_DAMPING: prdata = {16'd0, damping};
      REG_LIMIT:   prdata = {24'd0, iteration_limit};
      REG_TOL:     prdata = tolerance;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      damping         <= 16'd55706;
      iteration_limit <= 8'd100;
      tolerance       <= 32'd1074;
    end else if (apb_wr) begin
      case (paddr[3:2])
        REG_DAMPING: damping         <= pwdata[15:0];
        REG_LIMIT:   iteration_limit <= pwdata[7:0];
        REG_TOL:     tolerance       <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLR;
      i               <= '0;
      clr_resp        <= 1'b0;
      stored_edges    <= '0;
      highest_node    <= '0;
      last_iterations <= '0;
      last_converged  <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_RESP) m_tvalid <= 1'b0;
      case (state)
        S_CLR: begin
          i <= i_inc;
          if (32'(i_inc) == MAX_NODES) state <= clr_resp ? S_RESP : S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            status_r <= ST_OK;
            rank_r   <= '0;
            src_r    <= NODE_W'(in_src);
            case (in_act)
              ACT_ADD_EDGE: begin
                if (src_bad) begin
                  status_r <= ST_RANGE;
                  state    <= S_RESP;
                end else if (full) begin
                  status_r <= ST_FULL;
                  state    <= S_RESP;
                end else begin
                  stored_edges <= stored_edges + ECNT_W'(1);
                  if (NODE_W'(in_src) > highest_node && NODE_W'(in_src) >= NODE_W'(in_dst))
                    highest_node <= NODE_W'(in_src);
                  else if (NODE_W'(in_dst) > highest_node)
                    highest_node <= NODE_W'(in_dst);
                  state <= S_ADD;
                end
              end
              ACT_RUN: begin
                it    <= '0;
                conv  <= 1'b0;
                state <= S_DIV1;
              end
              ACT_READ: begin
                if (32'(in_idx) >= 32'(nc)) status_r <= ST_RANGE;
                state <= S_READ;
              end
              default: begin
                stored_edges <= '0;
                highest_node <= '0;
                i            <= '0;
                clr_resp     <= 1'b1;
                state        <= S_CLR;
              end
            endcase
          end
        end
        S_ADD:  state <= S_RESP;
        S_READ: begin
          if (status_r == ST_OK) rank_r <= old_q;
          state <= S_RESP;
        end
        S_DIV1: state <= S_W1;
        S_W1: begin
          if (drsp.done) begin
            init_r <= drsp.quotient;
            state  <= S_DIV2;
          end
        end
        S_DIV2: state <= S_W2;
        S_W2: begin
          if (drsp.done) begin
            base_r <= drsp.quotient;
            i      <= '0;
            state  <= S_FILL_OLD;
          end
        end
        S_FILL_OLD: begin
          i <= i_inc;
          if (i_inc == nc) state <= S_ITER;
        end
        S_ITER: begin
          i <= '0;
          if (it < iteration_limit && !conv) begin
            state <= S_FILL_NEW;
          end else begin
            last_iterations <= it;
            last_converged  <= conv;
            state           <= S_RESP;
          end
        end
        S_FILL_NEW: begin
          i <= i_inc;
          if (i_inc == nc) begin
            e     <= '0;
            state <= S_EDGE_RD;
          end
        end
        S_EDGE_RD: begin
          if (e == stored_edges) begin
            i     <= '0;
            diff  <= '0;
            state <= S_DIFF_RD;
          end else begin
            state <= S_EDGE_SRC;
          end
        end
        S_EDGE_SRC: begin
          v_r   <= edst_q;
          state <= S_EDGE_DEG;
        end
        S_EDGE_DEG: begin
          if (deg_q == '0) begin
            e     <= e + ECNT_W'(1);
            state <= S_EDGE_RD;
          end else begin
            state <= S_EDGE_DIV;
          end
        end
        S_EDGE_DIV: begin
          if (drsp.done) begin
            term_r <= prod[47:16];
            state  <= S_EDGE_ACC;
          end
        end
        S_EDGE_ACC: begin
          e     <= e + ECNT_W'(1);
          state <= S_EDGE_RD;
        end
        S_DIFF_RD: state <= S_DIFF_ACC;
        S_DIFF_ACC: begin
          diff <= diff + DIFF_W'(absdiff);
          i    <= i_inc;
          state <= (i_inc == nc) ? S_ITER_END : S_DIFF_RD;
        end
        S_ITER_END: begin
          conv  <= diff < DIFF_W'(tolerance);
          it    <= it + 8'd1;
          state <= S_ITER;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status_r;
            m_tdata  <= {5'd0, 15'(stored_edges), 11'(nc), last_converged,
                         last_iterations, rank_r};
            clr_resp <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_edges_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(stored_edges) <= 32'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy)
    else $error("divider started while busy");

  a_empty_graph: assert property (@(posedge clk) disable iff (rst)
    stored_edges == '0 |-> highest_node == '0)
    else $error("highest node set with no edges");

  a_resp_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_RANGE))
    else $error("undefined status code");
endmodule
`default_nettype wire
